[rtl/assert_macros.svh]
// assertion macros shared by the fade engine rtl
// expects clk and rst_n in the including scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every edge outside reset
`define VFE_HOLDS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition must never be seen outside reset
`define VFE_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

[rtl/vfe_pkg.sv]
// shared types and constants of the volume fade envelope unit
// no dependencies
package vfe_pkg;

  localparam int unsigned CNT_W = 5;

  localparam logic [15:0] ENV_UNITY  = 16'h8000;
  localparam logic [9:0]  GAIN_MAX   = 10'd512;
  localparam logic [9:0]  GAIN_UNITY = 10'd256;
  localparam logic [6:0]  BASE_RESET = 7'd100;
  localparam logic [7:0]  LEVEL_MAX  = 8'hff;

  // item kinds
  localparam logic [1:0] KIND_FADE  = 2'd0;
  localparam logic [1:0] KIND_TICK  = 2'd1;
  localparam logic [1:0] KIND_START = 2'd2;

  // fade kinds, also used as fade mode codes
  localparam logic [1:0] FADE_NONE       = 2'd0;
  localparam logic [1:0] FADE_IN         = 2'd1;
  localparam logic [1:0] FADE_OUT_STOP   = 2'd2;
  localparam logic [1:0] FADE_OUT_PAUSE  = 2'd3;

  // register indexes
  localparam logic [1:0] REG_BASE  = 2'd0;
  localparam logic [1:0] REG_PGAIN = 2'd1;
  localparam logic [1:0] REG_GGAIN = 2'd2;

  // shared unit operations
  localparam logic OP_MUL = 1'b0;
  localparam logic OP_DIV = 1'b1;

  typedef struct packed {
    logic             start;
    logic             op;
    logic [15:0]      a;      // multiplicand or divisor
    logic [15:0]      b;      // multiplier (left aligned) or dividend
    logic [CNT_W-1:0] nbits;  // number of steps
  } vfe_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [31:0] result;  // product, or quotient in the low half
  } vfe_rsp_t;

endpackage

[rtl/vfe_muldiv.sv]
// iterative shift-add multiplier and restoring divider on one adder
// depends on vfe_pkg and assert_macros.svh
`include "assert_macros.svh"

module vfe_muldiv (
  input  logic              clk,
  input  logic              rst_n,
  input  vfe_pkg::vfe_req_t req,
  output vfe_pkg::vfe_rsp_t rsp
);
  import vfe_pkg::*;

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic             op_r, op_nxt;
  logic [15:0]      a_r, a_nxt;
  logic [15:0]      b_r, b_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [31:0]      acc_r, acc_nxt;
  logic [15:0]      rem_r, rem_nxt;

  logic [32:0] x_op, y_op, sum;
  logic        sub, neg;

  // the one adder: accumulate for multiply, trial subtract for divide
  always_comb begin
    sub = (op_r == OP_DIV);
    if (sub) begin
      x_op = {16'b0, rem_r, b_r[15]};
      y_op = {17'b0, a_r};
    end else begin
      x_op = {acc_r, 1'b0};
      y_op = b_r[15] ? {17'b0, a_r} : 33'b0;
    end
    sum = x_op + (sub ? ~y_op : y_op) + {32'b0, sub};
    neg = sum[32];
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    op_nxt   = op_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    rem_nxt  = rem_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      op_nxt   = req.op;
      a_nxt    = req.a;
      b_nxt    = req.b;
      cnt_nxt  = req.nbits;
      acc_nxt  = '0;
      rem_nxt  = '0;
    end else if (busy_r) begin
      b_nxt   = {b_r[14:0], 1'b0};
      cnt_nxt = cnt_r - CNT_W'(1);
      if (sub) begin
        acc_nxt = {acc_r[30:0], ~neg};
        rem_nxt = neg ? x_op[15:0] : sum[15:0];
      end else begin
        acc_nxt = sum[31:0];
      end
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r  <= op_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    cnt_r <= cnt_nxt;
    acc_r <= acc_nxt;
    rem_r <= rem_nxt;
  end

  assign rsp.busy   = busy_r;
  assign rsp.done   = done_r;
  assign rsp.result = acc_r;

  `VFE_NEVER(a_done_while_busy, done_r && busy_r, "done flagged while still stepping")
  `VFE_HOLDS(a_busy_count, busy_r |-> (cnt_r != '0), "busy with no steps left")

endmodule

[rtl/volume_fade_envelope_unit.sv]
// top level of the volume fade envelope unit: registers, fade state, sequencer
// depends on vfe_pkg, vfe_muldiv and assert_macros.svh
//
//   port group | direction | carries
//   in_*       | slave     | fade command, tick or start of song
//   out_*      | master    | levels and flags, one per tick
//   cfg_*      | write     | base_volume, player_gain, group_gain
//
// a tick runs 7 + 16 + 10 add steps in the shared muldiv unit
// a fade-in command, or a fade-out command with a time, runs 16 divide steps; others skip the divider
// reset is synchronous and loads the power-on fade state, no clearing pass
// a result waits in the output register while the next item is taken; a second
// result holds the sequencer until the first transaction completes
`include "assert_macros.svh"

module volume_fade_envelope_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // fade_kind[1:0], fade_ticks[17:2], zeros
  input  logic [1:0]  in_tuser,   // kind[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // master_level[7:0], group_level[15:8],
                                  // is_paused[16], is_stopped[17], zeros
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [9:0]  cfg_wdata
);
  import vfe_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_MUL1 = 3'd3;
  localparam logic [2:0] S_MUL2 = 3'd4;
  localparam logic [2:0] S_MUL3 = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  logic [2:0]  state_r, state_nxt;
  logic [1:0]  kind_r, kind_nxt;
  logic [1:0]  fkind_r, fkind_nxt;
  logic [15:0] ticks_r, ticks_nxt;
  logic [6:0]  base_r, base_nxt;
  logic [9:0]  pgain_r, pgain_nxt;
  logic [9:0]  ggain_r, ggain_nxt;
  logic [1:0]  mode_r, mode_nxt;
  logic [15:0] env_r, env_nxt;
  logic [15:0] step_r, step_nxt;
  logic        paused_r, paused_nxt;
  logic        stopped_r, stopped_nxt;
  logic [7:0]  master_r, master_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [17:0] out_data_r, out_data_nxt;

  vfe_req_t req;
  vfe_rsp_t rsp;

  logic        need_div, cmd_apply;
  logic [15:0] env_sum;
  logic [7:0]  group_lvl;
  logic [9:0]  gain_sat;

  vfe_muldiv u_muldiv (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rsp   (rsp)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, out_data_r};

  assign need_div  = (fkind_r == FADE_IN) || (fkind_r[1] && (ticks_r != 16'd0));
  assign cmd_apply = ((state_r == S_EXEC) && (kind_r == KIND_FADE) && !need_div) ||
                     ((state_r == S_DIV) && rsp.done);
  assign env_sum   = env_r + step_r;
  assign group_lvl = (rsp.result[25:23] != 3'd0) ? LEVEL_MAX : rsp.result[22:15];
  assign gain_sat  = (cfg_wdata > GAIN_MAX) ? GAIN_MAX : cfg_wdata;

  always_comb begin
    state_nxt     = state_r;
    kind_nxt      = kind_r;
    fkind_nxt     = fkind_r;
    ticks_nxt     = ticks_r;
    base_nxt      = base_r;
    pgain_nxt     = pgain_r;
    ggain_nxt     = ggain_r;
    mode_nxt      = mode_r;
    env_nxt       = env_r;
    step_nxt      = step_r;
    paused_nxt    = paused_r;
    stopped_nxt   = stopped_r;
    master_nxt    = master_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_tready;
    req           = '0;

    if (cfg_we) begin
      case (cfg_addr)
        REG_BASE:  base_nxt  = cfg_wdata[6:0];
        REG_PGAIN: pgain_nxt = gain_sat;
        REG_GGAIN: ggain_nxt = gain_sat;
        default: ;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          kind_nxt  = in_tuser;
          fkind_nxt = in_tdata[1:0];
          ticks_nxt = in_tdata[17:2];
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_IDLE;
        case (kind_r)
          KIND_FADE: begin
            if (need_div) begin
              req.start = 1'b1;
              req.op    = OP_DIV;
              req.a     = (ticks_r == 16'd0) ? 16'd1 : ticks_r;
              req.b     = ENV_UNITY;
              req.nbits = CNT_W'(16);
              state_nxt = S_DIV;
            end
          end
          KIND_TICK: begin
            case (mode_r)
              FADE_IN: begin
                if (env_sum[15]) begin
                  mode_nxt = FADE_NONE;
                  env_nxt  = ENV_UNITY;
                  step_nxt = '0;
                end else begin
                  env_nxt = env_sum;
                end
              end
              FADE_OUT_STOP: begin
                if (env_r < step_r) begin
                  mode_nxt    = FADE_NONE;
                  env_nxt     = '0;
                  stopped_nxt = 1'b1;
                end else begin
                  env_nxt = env_r - step_r;
                end
              end
              FADE_OUT_PAUSE: begin
                if (env_r < step_r) begin
                  env_nxt    = '0;
                  paused_nxt = 1'b1;
                end else begin
                  env_nxt = env_r - step_r;
                end
              end
              default: ;
            endcase
            // base * player gain, base bits left aligned
            req.start = 1'b1;
            req.op    = OP_MUL;
            req.a     = {6'b0, pgain_r};
            req.b     = {base_r, 9'b0};
            req.nbits = CNT_W'(7);
            state_nxt = S_MUL1;
          end
          KIND_START: begin
            pgain_nxt   = GAIN_UNITY;
            ggain_nxt   = GAIN_UNITY;
            mode_nxt    = FADE_NONE;
            env_nxt     = ENV_UNITY;
            step_nxt    = '0;
            paused_nxt  = 1'b0;
            stopped_nxt = 1'b0;
          end
          default: ;
        endcase
      end
      S_DIV: begin
        if (rsp.done) state_nxt = S_IDLE;
      end
      S_MUL1: begin
        if (rsp.done) begin
          req.start = 1'b1;
          req.op    = OP_MUL;
          req.a     = rsp.result[15:0];
          req.b     = env_r;
          req.nbits = CNT_W'(16);
          state_nxt = S_MUL2;
        end
      end
      S_MUL2: begin
        if (rsp.done) begin
          master_nxt = rsp.result[31] ? LEVEL_MAX : rsp.result[30:23];
          // (vol >> 16) * group gain, gain bits left aligned
          req.start  = 1'b1;
          req.op     = OP_MUL;
          req.a      = rsp.result[31:16];
          req.b      = {ggain_r, 6'b0};
          req.nbits  = CNT_W'(10);
          state_nxt  = S_MUL3;
        end
      end
      S_MUL3: begin
        if (rsp.done) state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {stopped_r, paused_r, group_lvl, master_r};
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (cmd_apply) begin
      case (fkind_r)
        FADE_NONE: begin
          env_nxt  = ENV_UNITY;
          step_nxt = '0;
          mode_nxt = FADE_NONE;
        end
        FADE_IN: begin
          if (mode_r == FADE_NONE) env_nxt = '0;
          step_nxt   = rsp.result[15:0];
          paused_nxt = 1'b0;
          mode_nxt   = FADE_IN;
        end
        default: begin
          if (mode_r == FADE_NONE) env_nxt = ENV_UNITY;
          if (ticks_r != 16'd0) begin
            step_nxt = rsp.result[15:0];
            mode_nxt = fkind_r;
          end else begin
            env_nxt  = '0;
            step_nxt = 16'd1;
            if (fkind_r == FADE_OUT_STOP) begin
              mode_nxt    = FADE_NONE;
              stopped_nxt = 1'b1;
            end else begin
              mode_nxt   = FADE_OUT_PAUSE;
              paused_nxt = 1'b1;
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      base_r      <= BASE_RESET;
      pgain_r     <= GAIN_UNITY;
      ggain_r     <= GAIN_UNITY;
      mode_r      <= FADE_NONE;
      env_r       <= ENV_UNITY;
      step_r      <= '0;
      paused_r    <= 1'b0;
      stopped_r   <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      base_r      <= base_nxt;
      pgain_r     <= pgain_nxt;
      ggain_r     <= ggain_nxt;
      mode_r      <= mode_nxt;
      env_r       <= env_nxt;
      step_r      <= step_nxt;
      paused_r    <= paused_nxt;
      stopped_r   <= stopped_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r     <= kind_nxt;
    fkind_r    <= fkind_nxt;
    ticks_r    <= ticks_nxt;
    master_r   <= master_nxt;
    out_data_r <= out_data_nxt;
  end

  `VFE_NEVER(a_env_range, env_r > ENV_UNITY, "envelope above unity")
  `VFE_NEVER(a_start_busy, req.start && rsp.busy, "shared unit started while busy")
  `VFE_HOLDS(a_ready_idle, in_tready |-> !rsp.busy, "input ready while unit is busy")

endmodule
